### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication or plain property.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### sv/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Payload types and fixed field widths shared by the replacement unit.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int PAGE_IN_W = 16;
  localparam int FIDX_W    = 3;
  localparam int TIME_W    = 32;
  localparam int FAULT_W   = 32;
  localparam int CFG_W     = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic [PAGE_IN_W-1:0] page_number;
    logic                 end_of_string;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame_index;
    logic                 evicted_valid;
    logic [PAGE_IN_W-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;
  } out_t;

endpackage

### sv/lru_frame_store.sv
// ----------------------------------------------------------------------------
// LRU frame store
// One-write, one-read memory holding each frame's page and last-use time.
// ----------------------------------------------------------------------------
module lru_frame_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int PW    = 16,
  parameter int TW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [PW-1:0] wpage_i,
  input  logic [TW-1:0] wtime_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [PW-1:0] rpage_o,
  output logic [TW-1:0] rtime_o
);

  logic [PW-1:0] page_mem [DEPTH];
  logic [TW-1:0] time_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      page_mem[waddr_i] <= wpage_i;
      time_mem[waddr_i] <= wtime_i;
    end
  end

  // Read data is registered; it belongs to the address of the previous cycle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rpage_o <= page_mem[raddr_i];
      rtime_o <= time_mem[raddr_i];
    end
  end

endmodule

### sv/lru_page_replacement_unit.sv
// Each item runs a hit scan over the frames below both the fill count and the effective
// frame count, on a full miss an age scan over the effective frames, and an update step
// that waits while an earlier result has not been taken. The unit takes one item at a
// time: a new item is accepted only once the update step of the last one is done.
// Reset clears the frame count, reference time, fault count and handshake state;
// cfg_q returns to 8. Frame contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Keeps a set of resident page frames and picks the least recently used one
// for replacement on a page fault, reporting hit, frame, eviction and faults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_page_replacement_unit #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: number of frames that take part in replacement.
  input  logic                           cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Page reference input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lru_pkg::in_t                   in_data_i,
  // Result output channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lru_pkg::out_t                  out_data_o
);

  // Width of a frame index, and of a count that can hold FRAMES itself.
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  // Stored page width: the input field carries at most PAGE_IN_W bits.
  localparam int PW      = (PAGE_BITS < lru_pkg::PAGE_IN_W) ? PAGE_BITS : lru_pkg::PAGE_IN_W;
  localparam int TW      = lru_pkg::TIME_W;
  localparam int FLW     = lru_pkg::FAULT_W;
  localparam int FW      = lru_pkg::FIDX_W;
  localparam int PIW     = lru_pkg::PAGE_IN_W;
  localparam int CMP_W   = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;

  // The sequencer walks each item through the hit scan, an optional age scan
  // for the victim, and an update state that writes the frame store and
  // loads the result register.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HIT,
    S_AGE,
    S_WRITE
  } state_e;

  state_e                    state_q;
  logic [lru_pkg::CFG_W-1:0] cfg_q;
  logic [PW-1:0]             page_q;
  logic                      last_q;
  logic [CNT_W-1:0]          filled_q;
  logic [TW-1:0]             time_q;
  logic [FLW-1:0]            faults_q;
  logic [CNT_W-1:0]          scan_q;
  logic [CNT_W-1:0]          nf_q;
  logic [CNT_W-1:0]          ptr_q;
  logic                      rd_v_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic                      hit_q;
  logic [IDX_W-1:0]          slot_q;
  logic                      ev_v_q;
  logic [PW-1:0]             ev_page_q;
  logic [TW-1:0]             best_age_q;
  logic                      out_v_q;
  lru_pkg::out_t             out_q;

  logic [CMP_W-1:0]          cfg_ext;
  logic [CMP_W-1:0]          nf_ext;
  logic [CNT_W-1:0]          nf_c;
  logic [CNT_W-1:0]          scan_c;
  logic [CNT_W-1:0]          scan_m1;
  logic [CNT_W-1:0]          nf_m1;
  logic                      rd_issue;
  logic [PW-1:0]             rd_page;
  logic [TW-1:0]             rd_time;
  logic [TW-1:0]             age;
  logic                      match;
  logic                      hit_last;
  logic                      age_take;
  logic                      wr_go;
  logic [FLW-1:0]            faults_d;

  // Effective frame count: a register value of zero acts as one, and a value
  // above the number of built frames acts as that number.
  always_comb begin
    cfg_ext = CMP_W'(cfg_q);
    if (cfg_ext == '0) begin
      nf_ext = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      nf_ext = CMP_W'(FRAMES);
    end else begin
      nf_ext = cfg_ext;
    end
    nf_c = CNT_W'(nf_ext);
  end

  // The hit search covers only frames below both the fill count and the
  // effective count, so a lowered count hides the frames above it.
  assign scan_c  = (filled_q < nf_c) ? filled_q : nf_c;
  assign scan_m1 = scan_q - CNT_W'(1);
  assign nf_m1   = nf_q - CNT_W'(1);

  // One frame-store read per scan cycle while addresses remain; the data returns
  // in the next cycle, tagged by rd_idx_q.
  assign rd_issue = ((state_q == S_HIT) && (ptr_q < scan_q)) ||
                    ((state_q == S_AGE) && (ptr_q < nf_q));

  // The compare logic: page equality during the hit scan, and a modular
  // age subtract and compare during the victim scan.
  assign match    = rd_v_q && (rd_page == page_q);
  assign hit_last = rd_v_q && (rd_idx_q == scan_m1[IDX_W-1:0]);
  assign age      = time_q - rd_time;
  assign age_take = (rd_idx_q == '0) || (age > best_age_q);

  // The update cycle waits while an earlier result has not been taken.
  assign wr_go = (state_q == S_WRITE) && (!out_v_q || out_ready_i);

  // Saturating fault count for a miss.
  assign faults_d = (faults_q == '1) ? faults_q : faults_q + FLW'(1);

  lru_frame_store #(
    .DEPTH (FRAMES),
    .AW    (IDX_W),
    .PW    (PW),
    .TW    (TW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_go),
    .waddr_i (slot_q),
    .wpage_i (page_q),
    .wtime_i (time_q),
    .re_i    (rd_issue),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rpage_o (rd_page),
    .rtime_o (rd_time)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cfg_q      <= lru_pkg::CFG_RESET;
      page_q     <= '0;
      last_q     <= 1'b0;
      filled_q   <= '0;
      time_q     <= '0;
      faults_q   <= '0;
      scan_q     <= '0;
      nf_q       <= '0;
      ptr_q      <= '0;
      rd_v_q     <= 1'b0;
      rd_idx_q   <= '0;
      hit_q      <= 1'b0;
      slot_q     <= '0;
      ev_v_q     <= 1'b0;
      ev_page_q  <= '0;
      best_age_q <= '0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end

      rd_v_q   <= rd_issue;
      rd_idx_q <= ptr_q[IDX_W-1:0];
      if (rd_issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end

      // A result taken in the same cycle as a new one is loaded stays valid.
      if (out_v_q && out_ready_i && !wr_go) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            page_q  <= in_data_i.page_number[PW-1:0];
            last_q  <= in_data_i.end_of_string;
            nf_q    <= nf_c;
            scan_q  <= scan_c;
            ptr_q   <= '0;
            state_q <= S_HIT;
          end
        end

        S_HIT: begin
          if (match) begin
            hit_q     <= 1'b1;
            slot_q    <= rd_idx_q;
            ev_v_q    <= 1'b0;
            ev_page_q <= '0;
            state_q   <= S_WRITE;
          end else if ((scan_q == '0) || hit_last) begin
            // Page fault: fill the next empty frame if one is left,
            // otherwise look for the least recently used frame.
            hit_q     <= 1'b0;
            faults_q  <= faults_d;
            ev_v_q    <= 1'b0;
            ev_page_q <= '0;
            if (filled_q < nf_q) begin
              slot_q   <= filled_q[IDX_W-1:0];
              filled_q <= filled_q + CNT_W'(1);
              state_q  <= S_WRITE;
            end else begin
              ptr_q   <= '0;
              state_q <= S_AGE;
            end
          end
        end

        S_AGE: begin
          if (rd_v_q) begin
            // Strictly greater keeps ties on the lowest index.
            if (age_take) begin
              best_age_q <= age;
              slot_q     <= rd_idx_q;
              ev_page_q  <= rd_page;
            end
            if (rd_idx_q == nf_m1[IDX_W-1:0]) begin
              ev_v_q  <= 1'b1;
              state_q <= S_WRITE;
            end
          end
        end

        S_WRITE: begin
          if (wr_go) begin
            out_v_q                 <= 1'b1;
            out_q.hit               <= hit_q;
            out_q.frame_index       <= FW'(slot_q);
            out_q.evicted_valid     <= ev_v_q;
            out_q.evicted_page      <= PIW'(ev_page_q);
            out_q.fault_count       <= faults_q;
            // The end of a string clears the counts once its result is out.
            if (last_q) begin
              filled_q <= '0;
              time_q   <= '0;
              faults_q <= '0;
            end else begin
              time_q   <= time_q + TW'(1);
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `ASSERT_CLK(a_filled_bound, filled_q <= CNT_W'(FRAMES), "fill count exceeds frames")
  `ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "ready after transfer")
  `ASSERT_CLK(a_hit_no_evict, (out_valid_o && out_data_o.hit) |-> !out_data_o.evicted_valid,
              "hit with eviction")
  `ASSERT_CLK(a_evict_counts, (out_valid_o && out_data_o.evicted_valid) |->
              (out_data_o.fault_count != '0), "eviction without a counted fault")

endmodule
